[hw/rtl/xpie_pkg.sv]
// Package for the XOR parity interleave encoder.
// Holds result codes, controller/datapath command types and defaults.
// No dependencies.
`default_nettype none

package xpie_pkg;

   // default geometry
   localparam int CHECK_BYTES_DEF = 3;
   localparam int MAX_FRAME_DEF   = 1024;

   // fixed field widths of the channels
   localparam int KIND_W = 2;
   localparam int BYTE_W = 8;
   localparam int POS_W  = 10;

   // result kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_PARITY = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   // action codes of an input beat
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_READ = 1'b1;

   // commands from the controller to the datapath
   typedef enum logic [1:0] {
      OP_NONE,
      OP_LOAD,
      OP_READ,
      OP_CAPTURE
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic frame_ready;
      logic load_emit;
   } status_type;

endpackage

`default_nettype wire

[hw/rtl/xpie_req_if.sv]
// Input channel of the XOR parity interleave encoder: load/read beats.
// Depends on xpie_pkg for field widths.
`default_nettype none

interface xpie_req_if
   import xpie_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              action;
   logic [BYTE_W-1:0] data_byte;
   logic              frame_end;

   modport source (output valid, output action, output data_byte, output frame_end,
                   input ready);
   modport sink   (input valid, input action, input data_byte, input frame_end,
                   output ready);
endinterface

`default_nettype wire

[hw/rtl/xpie_rsp_if.sv]
// Result channel of the XOR parity interleave encoder.
// Depends on xpie_pkg for field widths.
`default_nettype none

interface xpie_rsp_if
   import xpie_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [BYTE_W-1:0] value;
   logic [POS_W-1:0]  position;
   logic              final_res;

   modport source (output valid, output kind, output value, output position,
                   output final_res, input ready);
   modport sink   (input valid, input kind, input value, input position,
                   input final_res, output ready);
endinterface

`default_nettype wire

[hw/rtl/xpie_ctrl.sv]
// Controller of the XOR parity interleave encoder: handshakes and sequencing.
// Depends on xpie_pkg; drives commands into xpie_dpath.
`default_nettype none

module xpie_ctrl
   import xpie_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_action,
   output      logic       req_ready,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output      cmd_type    cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_FETCH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   // take a beat only when idle and the output slot frees up
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // issue datapath commands
   always_comb begin
      cmd.op = OP_NONE;
      if (accept) begin
         cmd.op = (req_action == ACT_READ) ? OP_READ : OP_LOAD;
      end else if (state_ff == ST_FETCH) begin
         cmd.op = OP_CAPTURE;
      end
   end

   // next state and output valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ACT_READ) begin
                  if (status.frame_ready) begin
                     state_in = ST_FETCH;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end else begin
                  rsp_valid_in = status.load_emit;
               end
            end
         end
         ST_FETCH: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state and registered valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/xpie_dpath.sv]
// Datapath of the XOR parity interleave encoder: frame memory, counters,
// parity accumulator and result registers. Depends on xpie_pkg.
`default_nettype none

module xpie_dpath
   import xpie_pkg::*;
#(
   parameter int CHECK_BYTES = CHECK_BYTES_DEF,
   parameter int MAX_FRAME   = MAX_FRAME_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cmd_type           cmd,
   input  wire logic [BYTE_W-1:0] data_byte,
   input  wire logic              frame_end,
   output      status_type        status,
   output      logic [KIND_W-1:0] kind,
   output      logic [BYTE_W-1:0] value,
   output      logic [POS_W-1:0]  position,
   output      logic              final_res
);

   localparam int AW = $clog2(MAX_FRAME);
   localparam int CW = $clog2(MAX_FRAME + 1);
   localparam int GW = $clog2(CHECK_BYTES);

   // frame memory
   logic [BYTE_W-1:0] mem [MAX_FRAME];
   logic [BYTE_W-1:0] mem_rd_ff;

   // frame state
   logic              ready_ff, ready_in;
   logic [BYTE_W-1:0] acc_ff, acc_in;
   logic [CW-1:0]     bcnt_ff, bcnt_in;
   logic [GW-1:0]     gpos_ff, gpos_in;
   logic [CW-1:0]     gcnt_ff, gcnt_in;
   logic [CW-1:0]     row_ff, row_in;
   logic [GW-1:0]     col_ff, col_in;
   logic [AW-1:0]     raddr_ff, raddr_in;
   logic [CW-1:0]     k_ff, k_in;

   // result payload
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [BYTE_W-1:0] value_ff, value_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              fin_ff, fin_in;

   // load view: a finished frame is dropped before the new byte lands
   logic [BYTE_W-1:0] ld_acc;
   logic [CW-1:0]     ld_bcnt;
   logic [GW-1:0]     ld_gpos;
   logic [CW-1:0]     ld_gcnt;
   logic              ld_full;
   logic              ld_gend;
   logic [BYTE_W-1:0] ld_par;
   logic              mem_we;
   logic              rd_fin;
   logic              rd_wrap;

   assign ld_acc  = ready_ff ? '0 : acc_ff;
   assign ld_bcnt = ready_ff ? '0 : bcnt_ff;
   assign ld_gpos = ready_ff ? '0 : gpos_ff;
   assign ld_gcnt = ready_ff ? '0 : gcnt_ff;
   assign ld_full = (ld_bcnt == CW'(MAX_FRAME));
   assign ld_gend = (ld_gpos == GW'(CHECK_BYTES - 1));
   assign ld_par  = ld_acc ^ data_byte;

   assign rd_fin  = (k_ff + CW'(1)) == bcnt_ff;
   assign rd_wrap = (row_ff + CW'(1)) == gcnt_ff;

   assign status.frame_ready = ready_ff;
   assign status.load_emit   = ld_full || ld_gend || frame_end;

   assign mem_we = (cmd.op == OP_LOAD) && !ld_full;

   // next-state logic per command
   always_comb begin
      ready_in = ready_ff;
      acc_in   = acc_ff;
      bcnt_in  = bcnt_ff;
      gpos_in  = gpos_ff;
      gcnt_in  = gcnt_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      raddr_in = raddr_ff;
      k_in     = k_ff;
      kind_in  = kind_ff;
      value_in = value_ff;
      pos_in   = pos_ff;
      fin_in   = fin_ff;
      case (cmd.op)
         OP_LOAD: begin
            ready_in = 1'b0;
            acc_in   = ld_acc;
            bcnt_in  = ld_bcnt;
            gpos_in  = ld_gpos;
            gcnt_in  = ld_gcnt;
            row_in   = '0;
            col_in   = '0;
            raddr_in = '0;
            k_in     = '0;
            if (ld_full || (!ld_gend && frame_end)) begin
               // overflow or short last group: drop the frame
               acc_in   = '0;
               bcnt_in  = '0;
               gpos_in  = '0;
               gcnt_in  = '0;
               kind_in  = KIND_ERROR;
               value_in = '0;
               pos_in   = '0;
               fin_in   = 1'b0;
            end else if (ld_gend) begin
               // close the group and emit its parity
               acc_in   = '0;
               bcnt_in  = ld_bcnt + CW'(1);
               gpos_in  = '0;
               gcnt_in  = ld_gcnt + CW'(1);
               ready_in = frame_end;
               kind_in  = KIND_PARITY;
               value_in = ld_par;
               pos_in   = POS_W'(ld_gcnt);
               fin_in   = frame_end;
            end else begin
               acc_in  = ld_par;
               bcnt_in = ld_bcnt + CW'(1);
               gpos_in = ld_gpos + GW'(1);
            end
         end
         OP_READ: begin
            if (!ready_ff) begin
               kind_in  = KIND_ERROR;
               value_in = '0;
               pos_in   = '0;
               fin_in   = 1'b0;
            end else begin
               kind_in = KIND_DATA;
               pos_in  = POS_W'(k_ff);
               fin_in  = rd_fin;
               if (rd_fin) begin
                  // last byte out: back to an empty frame
                  ready_in = 1'b0;
                  acc_in   = '0;
                  bcnt_in  = '0;
                  gpos_in  = '0;
                  gcnt_in  = '0;
                  row_in   = '0;
                  col_in   = '0;
                  raddr_in = '0;
                  k_in     = '0;
               end else if (rd_wrap) begin
                  // next column starts at the top row
                  row_in   = '0;
                  col_in   = col_ff + GW'(1);
                  raddr_in = AW'(col_ff) + AW'(1);
                  k_in     = k_ff + CW'(1);
               end else begin
                  row_in   = row_ff + CW'(1);
                  raddr_in = raddr_ff + AW'(CHECK_BYTES);
                  k_in     = k_ff + CW'(1);
               end
            end
         end
         OP_CAPTURE: begin
            value_in = mem_rd_ff;
         end
         default: begin
         end
      endcase
   end

   // write loaded bytes, read the interleaved entry
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[ld_bcnt[AW-1:0]] <= data_byte;
      end
      if (cmd.op == OP_READ) begin
         mem_rd_ff <= mem[raddr_ff];
      end
   end

   // hold frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= 1'b0;
         acc_ff   <= '0;
         bcnt_ff  <= '0;
         gpos_ff  <= '0;
         gcnt_ff  <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         raddr_ff <= '0;
         k_ff     <= '0;
      end else begin
         ready_ff <= ready_in;
         acc_ff   <= acc_in;
         bcnt_ff  <= bcnt_in;
         gpos_ff  <= gpos_in;
         gcnt_ff  <= gcnt_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         raddr_ff <= raddr_in;
         k_ff     <= k_in;
      end
   end

   // hold result payload
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      value_ff <= value_in;
      pos_ff   <= pos_in;
      fin_ff   <= fin_in;
   end

   assign kind      = kind_ff;
   assign value     = value_ff;
   assign position  = pos_ff;
   assign final_res = fin_ff;

endmodule

`default_nettype wire

[hw/rtl/xor_parity_interleave_encoder.sv]
// XOR parity interleave encoder, top level.
// Load beats (action 0) bring frame bytes in order, frame_end on the last.
// Each completed group of CHECK_BYTES bytes gives a parity beat on rsp.
// Once a frame is complete, read beats (action 1) return the frame
// transposed as rows of CHECK_BYTES bytes, one byte per beat.
// Short last group, overflow past MAX_FRAME bytes and early reads give
// an error beat; a load during readout starts a new frame.
// A load's result is on rsp the cycle after acceptance; a read of a finished
// frame passes the registered read port of the frame memory and the fetch
// state first. One load per cycle while rsp is not stalled; such a read holds
// req_ready low in the fetch state, so the next beat waits for its byte.
// A beat is taken while a finished result is being drained; when the
// receiver stalls with a result waiting, req_ready drops until it is taken.
// Reset (synchronous) empties the frame and the output; the memory needs
// no clearing since only bytes written in the current frame are read.
// Depends on xpie_pkg, xpie_req_if, xpie_rsp_if, xpie_ctrl, xpie_dpath.
`default_nettype none

module xor_parity_interleave_encoder
   import xpie_pkg::*;
#(
   parameter int CHECK_BYTES = CHECK_BYTES_DEF,
   parameter int MAX_FRAME   = MAX_FRAME_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   xpie_req_if.sink   req_bus,
   xpie_rsp_if.source rsp_bus
);

   cmd_type    cmd;
   status_type status;

   // sequence handshakes and commands
   xpie_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_action (req_bus.action),
      .req_ready  (req_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .status     (status),
      .cmd        (cmd)
   );

   // frame storage and result computation
   xpie_dpath #(
      .CHECK_BYTES (CHECK_BYTES),
      .MAX_FRAME   (MAX_FRAME)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .data_byte (req_bus.data_byte),
      .frame_end (req_bus.frame_end),
      .status    (status),
      .kind      (rsp_bus.kind),
      .value     (rsp_bus.value),
      .position  (rsp_bus.position),
      .final_res (rsp_bus.final_res)
   );

endmodule

`default_nettype wire

[tb/xpie_tb_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard for the XOR parity interleave encoder testbench: predicts the
// result, if any, of each accepted input beat and checks the result channel.
// Depends on xpie_pkg.

package xpie_tb_pkg;
   import xpie_pkg::*;

   localparam int GROUP_LEN = CHECK_BYTES_DEF;
   localparam int FRAME_CAP = MAX_FRAME_DEF;
   localparam int REPORT_MAX = 10;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] value;
      logic [POS_W-1:0]  position;
      logic              final_res;
   } enc_beat_type;

   class encoder_scoreboard;
      // mirror of the encoder state
      logic [BYTE_W-1:0] frame_bytes [FRAME_CAP];
      logic [BYTE_W-1:0] parity;
      logic [10:0]       byte_count;
      logic [3:0]        group_pos;
      logic [POS_W-1:0]  group_idx;
      logic [POS_W-1:0]  row;
      logic [3:0]        col;
      bit                frame_done;

      // result beats owed by the encoder, oldest first
      enc_beat_type due_beats[$];
      int           failures;
      int           reported;

      function new();
         clear_frame();
         failures = 0;
         reported = 0;
      endfunction

      function void clear_frame();
         parity     = '0;
         byte_count = '0;
         group_pos  = '0;
         group_idx  = '0;
         row        = '0;
         col        = '0;
         frame_done = 1'b0;
      endfunction

      function void push_beat(kind_type kind, logic [BYTE_W-1:0] value,
                              logic [POS_W-1:0] position, logic fin);
         enc_beat_type b;
         b.kind      = kind;
         b.value     = value;
         b.position  = position;
         b.final_res = fin;
         due_beats.push_back(b);
      endfunction

      // Load: store byte, fold it into the group parity, close groups and frames.
      function void absorb_byte(logic [BYTE_W-1:0] b, logic last);
         if (frame_done) begin
            clear_frame();
         end
         // drop the byte and the frame on overflow
         if (byte_count >= FRAME_CAP) begin
            clear_frame();
            push_beat(KIND_ERROR, '0, '0, 1'b0);
            return;
         end
         frame_bytes[byte_count] = b;
         byte_count++;
         parity = parity ^ b;
         group_pos++;
         if (group_pos >= GROUP_LEN) begin
            push_beat(KIND_PARITY, parity, group_idx, last);
            parity    = '0;
            group_pos = '0;
            group_idx++;
            if (last) begin
               frame_done = 1'b1;
               row        = '0;
               col        = '0;
            end
            return;
         end
         // frame ends inside a group: discard it
         if (last) begin
            clear_frame();
            push_beat(KIND_ERROR, '0, '0, 1'b0);
         end
      endfunction

      // Read: walk the frame column by column over rows of GROUP_LEN bytes.
      function void fetch_interleaved();
         int               rows;
         int               idx;
         int               k;
         bit               fin;
         logic [BYTE_W-1:0] b;
         if (!frame_done) begin
            push_beat(KIND_ERROR, '0, '0, 1'b0);
            return;
         end
         rows = byte_count / GROUP_LEN;
         if (rows == 0) begin
            clear_frame();
            push_beat(KIND_ERROR, '0, '0, 1'b0);
            return;
         end
         idx = row * GROUP_LEN + col;
         b   = (idx < FRAME_CAP) ? frame_bytes[idx] : '0;
         k   = col * rows + row;
         fin = (col + 1 >= GROUP_LEN) && (row + 1 >= rows);
         push_beat(KIND_DATA, b, k[POS_W-1:0], fin);
         if (fin) begin
            clear_frame();
         end else begin
            row++;
            if (row >= rows) begin
               row = '0;
               col++;
            end
         end
      endfunction

      // Note one accepted input beat and queue the result, if any, that it causes.
      function void note_beat(logic act, logic [BYTE_W-1:0] data, logic fe);
         if (act == ACT_READ) begin
            fetch_interleaved();
         end else begin
            absorb_byte(data, fe);
         end
      endfunction

      // Check one accepted result beat against the oldest owed one.
      function void check_result(enc_beat_type got);
         enc_beat_type want;
         if (due_beats.size() == 0) begin
            failures++;
            if (reported < REPORT_MAX) begin
               reported++;
               $display("unexpected result: kind %0d value %02h position %0d final %0d",
                        got.kind, got.value, got.position, got.final_res);
            end
            return;
         end
         want = due_beats.pop_front();
         if (got.kind !== want.kind || got.value !== want.value ||
             got.position !== want.position || got.final_res !== want.final_res) begin
            failures++;
            if (reported < REPORT_MAX) begin
               reported++;
               $display("mismatch: expected kind %0d value %02h position %0d final %0d",
                        want.kind, want.value, want.position, want.final_res);
               $display("          got      kind %0d value %02h position %0d final %0d",
                        got.kind, got.value, got.position, got.final_res);
            end
         end
      endfunction

      function int due_count();
         return due_beats.size();
      endfunction
   endclass

endpackage

[tb/xor_parity_interleave_encoder_test.sv]
`timescale 1ns / 100ps
// Top of the XOR parity interleave encoder testbench: directed frames and an
// overflow, then random frame traffic with stalls.
// Depends on xpie_pkg, xpie_req_if, xpie_rsp_if, xpie_tb_pkg and the encoder.

module xor_parity_interleave_encoder_test;
   import xpie_pkg::*;
   import xpie_tb_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_BEATS = 300;
   localparam int DRAIN_CYCLES = 10;

   logic clock;
   logic reset;
   int   send_idle_pct = 18;
   int   recv_idle_pct = 49;
   int   beats_sent    = 0;

   encoder_scoreboard score;

   xpie_req_if req_bus();
   xpie_rsp_if rsp_bus();

   xor_parity_interleave_encoder #(
      .CHECK_BYTES(CHECK_BYTES_DEF),
      .MAX_FRAME  (MAX_FRAME_DEF)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // give up on a hung run
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   // stall the result channel at random
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // check each accepted result beat
   always @(posedge clock) begin : take_result
      enc_beat_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.kind      = kind_type'(rsp_bus.kind);
         got.value     = rsp_bus.value;
         got.position  = rsp_bus.position;
         got.final_res = rsp_bus.final_res;
         score.check_result(got);
      end
   end

   // Drive one beat, idling first at random, and note it once accepted.
   task automatic send_beat(input logic act, input logic [BYTE_W-1:0] data,
                            input logic fe);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.action    <= act;
      req_bus.data_byte <= data;
      req_bus.frame_end <= fe;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      score.note_beat(act, data, fe);
      beats_sent++;
   endtask

   task automatic load_bytes(input int n, input bit with_end);
      for (int i = 0; i < n; i++) begin
         send_beat(ACT_LOAD, BYTE_W'($urandom), with_end && (i == n - 1));
      end
   endtask

   // frame_end is random on reads, the encoder ignores it there
   task automatic read_bytes(input int n);
      for (int i = 0; i < n; i++) begin
         send_beat(ACT_READ, BYTE_W'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      int start;
      int pick;
      int groups;
      int tail;

      score              = new();
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.action     = ACT_LOAD;
      req_bus.data_byte  = '0;
      req_bus.frame_end  = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // read with nothing loaded
      send_beat(ACT_READ, 8'hFF, 1'b1);
      // one group, full readout, then read past the end
      send_beat(ACT_LOAD, 8'h00, 1'b0);
      send_beat(ACT_LOAD, 8'hFF, 1'b0);
      send_beat(ACT_LOAD, 8'h5A, 1'b1);
      read_bytes(3);
      send_beat(ACT_READ, 8'h00, 1'b0);
      // frame ends inside a group
      send_beat(ACT_LOAD, 8'h81, 1'b0);
      send_beat(ACT_LOAD, 8'h7E, 1'b1);
      // two groups, readout cut short by a new frame
      send_beat(ACT_LOAD, 8'hFF, 1'b0);
      send_beat(ACT_LOAD, 8'h01, 1'b0);
      send_beat(ACT_LOAD, 8'h80, 1'b0);
      send_beat(ACT_LOAD, 8'h7E, 1'b0);
      send_beat(ACT_LOAD, 8'h00, 1'b0);
      send_beat(ACT_LOAD, 8'hC3, 1'b1);
      read_bytes(2);
      send_beat(ACT_LOAD, 8'h12, 1'b0);
      send_beat(ACT_LOAD, 8'hA5, 1'b0);
      send_beat(ACT_LOAD, 8'hEF, 1'b1);
      read_bytes(3);

      // overflow: a full buffer and one byte more
      load_bytes(MAX_FRAME_DEF, 1'b0);
      send_beat(ACT_LOAD, 8'h3C, 1'b1);

      // random frame traffic in three idling phases
      start = beats_sent;
      while (beats_sent - start < RANDOM_BEATS) begin
         if (beats_sent - start >= 2 * RANDOM_BEATS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else if (beats_sent - start >= RANDOM_BEATS / 3) begin
            send_idle_pct = 49;
            recv_idle_pct = 18;
         end
         pick = $urandom_range(99);
         if (pick < 70) begin
            // well-formed frame, mostly small
            groups = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            load_bytes(groups * CHECK_BYTES_DEF, 1'b1);
            tail = $urandom_range(9);
            if (tail < 6) begin
               read_bytes(groups * CHECK_BYTES_DEF);
            end else if (tail < 8) begin
               read_bytes($urandom_range(1, groups * CHECK_BYTES_DEF - 1));
            end else begin
               read_bytes(groups * CHECK_BYTES_DEF + $urandom_range(1, 2));
            end
         end else if (pick < 80) begin
            // frame of any length, often cut inside a group
            load_bytes($urandom_range(1, 20), 1'b1);
         end else if (pick < 90) begin
            // early read in the middle of a load
            load_bytes($urandom_range(1, 6), 1'b0);
            read_bytes(1);
         end else begin
            read_bytes($urandom_range(1, 3));
         end
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (score.due_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (score.failures == 0 && score.due_count() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/xpie_pkg.sv
hw/rtl/xpie_req_if.sv
hw/rtl/xpie_rsp_if.sv
hw/rtl/xpie_ctrl.sv
hw/rtl/xpie_dpath.sv
hw/rtl/xor_parity_interleave_encoder.sv
tb/xpie_tb_pkg.sv
tb/xor_parity_interleave_encoder_test.sv
